// ===== rtl/core/gf_p2_ntt_butterfly_assert.svh =====
// Assertion macros for the GF(p^2) butterfly core.
// Self-contained; included by the top level, which supplies clock and reset.
`ifndef GF_P2_NTT_BUTTERFLY_ASSERT_SVH
`define GF_P2_NTT_BUTTERFLY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GFNTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent must hold after the delay dly.
`define GFNTT_ASSERT_LAT(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gfntt_pkg.sv =====
// Types, constants and modular helpers for the GF(p^2) butterfly, p = 2^61 - 1.
// No dependencies.
package gfntt_pkg;

    localparam int unsigned W = 61;
    localparam logic [W-1:0] P_MOD = {W{1'b1}};

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_op;

    typedef struct packed {
        t_op          opcode;
        logic [W-1:0] first_re;
        logic [W-1:0] first_im;
        logic [W-1:0] second_re;
        logic [W-1:0] second_im;
        logic [W-1:0] twiddle_re;
        logic [W-1:0] twiddle_im;
    } t_bfly_in;

    typedef struct packed {
        logic [W-1:0] sum_re;
        logic [W-1:0] sum_im;
        logic [W-1:0] diff_re;
        logic [W-1:0] diff_im;
    } t_bfly_out;

    // All ones is p itself: map it to zero.
    function automatic logic [W-1:0] f_canon(input logic [W-1:0] v);
        return (v == P_MOD) ? '0 : v;
    endfunction

    function automatic logic [W-1:0] f_madd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) begin
            s = s - {1'b0, P_MOD};
        end
        return s[W-1:0];
    endfunction

    // Wraps mod 2^62 on borrow, so adding p lands on a - b + p.
    function automatic logic [W-1:0] f_msub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[W]) begin
            d = d + {1'b0, P_MOD};
        end
        return d[W-1:0];
    endfunction

    // Times 2^60 = 2^-1 mod p: a one-bit rotate right, canonical in and out.
    function automatic logic [W-1:0] f_half(input logic [W-1:0] v);
        return {v[0], v[W-1:1]};
    endfunction

endpackage

// ===== rtl/core/gf_p2_ntt_butterfly.sv =====
// Radix-2 NTT butterfly over GF(p^2), p = 2^61 - 1: seven-stage pipeline.
// Depends on gfntt_pkg and gf_p2_ntt_butterfly_assert.svh.
//
// One butterfly beat enters on every cycle that start is high and busy is low;
// busy is only high in and right after reset. Opcode OP_FWD gives
// sum = a + b, diff = (a - b) * w; opcode OP_INV gives t = b * w,
// sum = (a + t) / 2, diff = (a - t) / 2. An input of all ones counts as zero.
// Every accepted beat comes out at the end of the pipeline, as one cycle of
// o_valid with the result on o_out; results keep input order. The receiver
// cannot stall, so nothing ever waits inside. The depth is set by the
// complex multiply: each 61x61 product is built from 32x32 partial products
// (one stage), summed (one stage) and folded mod p in two stages, then the
// complex terms combine and the final add, subtract and halving follow.
`include "gf_p2_ntt_butterfly_assert.svh"

module gf_p2_ntt_butterfly (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gfntt_pkg::t_bfly_in   i_in,
    output logic                  o_valid,
    output gfntt_pkg::t_bfly_out  o_out
);
    import gfntt_pkg::*;

    localparam int unsigned LATENCY = 7;
    localparam int unsigned NMUL    = 4;   // mr*wr, mi*wi, mi*wr, mr*wi
    localparam int unsigned HW      = 32;  // partial product split point
    localparam int unsigned PW      = 2 * W;

    // ---------------------------------------------------------------
    // Control: valid bits ride along with the data.
    // ---------------------------------------------------------------
    logic               r_alive;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;
    logic               accept;

    assign busy   = !i_rst_n || !r_alive;
    assign accept = start && !busy;
    assign n_vld  = {r_vld[LATENCY-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_alive <= 1'b1;
            r_vld   <= n_vld;
        end
    end

    // ---------------------------------------------------------------
    // Side payload carried down to the last stage.
    // op, a (for the inverse) and a + b (for the forward sum).
    // ---------------------------------------------------------------
    t_op          r_op [1:LATENCY-1];
    logic [W-1:0] r_ar [1:LATENCY-1];
    logic [W-1:0] r_ai [1:LATENCY-1];
    logic [W-1:0] r_xr [1:LATENCY-1];
    logic [W-1:0] r_xi [1:LATENCY-1];

    // Stage 1: canonize, form the multiplicand.
    logic [W-1:0] n1_ar, n1_ai, n1_br, n1_bi, n1_wr, n1_wi;
    logic [W-1:0] n1_mr, n1_mi;
    logic [W-1:0] r1_mr, r1_mi, r1_wr, r1_wi;

    always_comb begin
        n1_ar = f_canon(i_in.first_re);
        n1_ai = f_canon(i_in.first_im);
        n1_br = f_canon(i_in.second_re);
        n1_bi = f_canon(i_in.second_im);
        n1_wr = f_canon(i_in.twiddle_re);
        n1_wi = f_canon(i_in.twiddle_im);
        // Forward multiplies (a - b) by w, inverse multiplies b by w.
        if (i_in.opcode == OP_INV) begin
            n1_mr = n1_br;
            n1_mi = n1_bi;
        end else begin
            n1_mr = f_msub(n1_ar, n1_br);
            n1_mi = f_msub(n1_ai, n1_bi);
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[1] <= i_in.opcode;
        r_ar[1] <= n1_ar;
        r_ai[1] <= n1_ai;
        r_xr[1] <= f_madd(n1_ar, n1_br);
        r_xi[1] <= f_madd(n1_ai, n1_bi);
        r1_mr   <= n1_mr;
        r1_mi   <= n1_mi;
        r1_wr   <= n1_wr;
        r1_wi   <= n1_wi;
    end

    // Advance the side payload one stage per cycle.
    always_ff @(posedge i_clk) begin
        for (int s = 2; s < LATENCY; s++) begin
            r_op[s] <= r_op[s-1];
            r_ar[s] <= r_ar[s-1];
            r_ai[s] <= r_ai[s-1];
            r_xr[s] <= r_xr[s-1];
            r_xi[s] <= r_xi[s-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: sixteen 32x32 partial products (four per 61x61 product).
    // Operands are zero-extended to the product width.
    // ---------------------------------------------------------------
    logic [W-1:0]      n2_x [NMUL];
    logic [W-1:0]      n2_y [NMUL];
    logic [2*HW-1:0]   r2_ll [NMUL];
    logic [2*HW-1:0]   r2_lh [NMUL];
    logic [2*HW-1:0]   r2_hl [NMUL];
    logic [2*HW-1:0]   r2_hh [NMUL];

    always_comb begin
        n2_x[0] = r1_mr;  n2_y[0] = r1_wr;
        n2_x[1] = r1_mi;  n2_y[1] = r1_wi;
        n2_x[2] = r1_mi;  n2_y[2] = r1_wr;
        n2_x[3] = r1_mr;  n2_y[3] = r1_wi;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NMUL; k++) begin
            r2_ll[k] <= {{HW{1'b0}}, n2_x[k][HW-1:0]}
                      * {{HW{1'b0}}, n2_y[k][HW-1:0]};
            r2_lh[k] <= {{HW{1'b0}}, n2_x[k][HW-1:0]}
                      * {{(3*HW-W){1'b0}}, n2_y[k][W-1:HW]};
            r2_hl[k] <= {{(3*HW-W){1'b0}}, n2_x[k][W-1:HW]}
                      * {{HW{1'b0}}, n2_y[k][HW-1:0]};
            r2_hh[k] <= {{(3*HW-W){1'b0}}, n2_x[k][W-1:HW]}
                      * {{(3*HW-W){1'b0}}, n2_y[k][W-1:HW]};
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: assemble the full 122-bit products.
    // ---------------------------------------------------------------
    logic [PW-1:0] r3_prod [NMUL];
    logic [2*HW:0] n3_mid  [NMUL];

    always_comb begin
        for (int k = 0; k < NMUL; k++) begin
            n3_mid[k] = {1'b0, r2_lh[k]} + {1'b0, r2_hl[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NMUL; k++) begin
            r3_prod[k] <= {r2_hh[k][PW-2*HW-1:0], r2_ll[k]}
                        + {{(PW-3*HW-1){1'b0}}, n3_mid[k], {HW{1'b0}}};
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: first fold, 2^61 = 1 mod p.
    // Stage 5: second fold to a canonical residue.
    // ---------------------------------------------------------------
    logic [W:0]   r4_fold [NMUL];
    logic [W-1:0] n5_red  [NMUL];
    logic [W-1:0] r5_m    [NMUL];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NMUL; k++) begin
            r4_fold[k] <= {1'b0, r3_prod[k][W-1:0]} + {1'b0, r3_prod[k][PW-1:W]};
        end
    end

    // The fold is at most 2^62 - 2, so one more carry-in cannot pass p.
    always_comb begin
        for (int k = 0; k < NMUL; k++) begin
            n5_red[k] = f_canon(r4_fold[k][W-1:0] + {{(W-1){1'b0}}, r4_fold[k][W]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NMUL; k++) begin
            r5_m[k] <= n5_red[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: complex combine, (mr*wr - mi*wi, mi*wr + mr*wi).
    // ---------------------------------------------------------------
    logic [W-1:0] r6_tr, r6_ti;

    always_ff @(posedge i_clk) begin
        r6_tr <= f_msub(r5_m[0], r5_m[1]);
        r6_ti <= f_madd(r5_m[2], r5_m[3]);
    end

    // ---------------------------------------------------------------
    // Stage 7: output register. Forward passes a + b and the product;
    // inverse adds and subtracts t, then halves.
    // ---------------------------------------------------------------
    t_bfly_out n7_out;
    t_bfly_out r7_out;

    always_comb begin
        if (r_op[LATENCY-1] == OP_INV) begin
            n7_out.sum_re  = f_half(f_madd(r_ar[LATENCY-1], r6_tr));
            n7_out.sum_im  = f_half(f_madd(r_ai[LATENCY-1], r6_ti));
            n7_out.diff_re = f_half(f_msub(r_ar[LATENCY-1], r6_tr));
            n7_out.diff_im = f_half(f_msub(r_ai[LATENCY-1], r6_ti));
        end else begin
            n7_out.sum_re  = r_xr[LATENCY-1];
            n7_out.sum_im  = r_xi[LATENCY-1];
            n7_out.diff_re = r6_tr;
            n7_out.diff_im = r6_ti;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_out <= n7_out;
    end

    assign o_valid = r_vld[LATENCY-1];
    assign o_out   = r7_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `GFNTT_ASSERT_LAT(a_beat_out, i_clk, i_rst_n, accept, 7, o_valid,
        "accepted beat did not come out after the pipeline latency")
    `GFNTT_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n, o_valid, $past(accept, LATENCY),
        "result strobe without a matching accepted beat")
    `GFNTT_ASSERT_NOW(a_canonical, i_clk, i_rst_n, o_valid,
        o_out.sum_re != P_MOD && o_out.sum_im != P_MOD &&
        o_out.diff_re != P_MOD && o_out.diff_im != P_MOD,
        "result residue not canonical")

endmodule
